// ===== hw/rtl/brfs_pkg.sv =====
// Shared types and constants for the byte ring FIFO with search.
package brfs_pkg;

    // Ring geometry; pointers wrap at twice the ring depth.
    localparam int DEPTH  = 64;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int PTR_W  = 7;
    localparam int LEN_W  = 7;
    localparam int OFS_W  = 6;

    // Input kind codes as they arrive on the stream.
    localparam logic [2:0] KIND_WRITE   = 3'd0;
    localparam logic [2:0] KIND_READ    = 3'd1;
    localparam logic [2:0] KIND_PEEK    = 3'd2;
    localparam logic [2:0] KIND_DISCARD = 3'd3;
    localparam logic [2:0] KIND_FIND    = 3'd4;

    // Decoded operation handed from the front to the back.
    typedef enum logic [2:0] {
        OP_WRITE   = 3'd0,
        OP_READ    = 3'd1,
        OP_PEEK    = 3'd2,
        OP_DISCARD = 3'd3,
        OP_FIND    = 3'd4,
        OP_NONE    = 3'd5
    } op_t;

    // One queued command: the byte is the write byte or the search byte.
    typedef struct packed {
        op_t              op;
        logic [7:0]       data;
        logic [LEN_W-1:0] length;
    } cmd_t;

    // One result item.
    typedef struct packed {
        logic [7:0]       data_byte;
        logic             data_valid;
        logic             last;
        logic [LEN_W-1:0] count;
        logic             found;
        logic [OFS_W-1:0] offset;
        logic [PTR_W-1:0] fill_level;
        logic             is_empty;
        logic             is_full;
    } res_t;

endpackage

// ===== hw/rtl/byte_ring_fifo_with_search_top.sv =====
// Top level of the byte ring FIFO with search.
//
//   Channel  Direction  tdata (lowest bit up)                         tuser       tlast
//   s_       in         write_byte, length, search_byte, pad to 24   kind        -
//   m_       out        data_byte, count, found, offset, fill_level,  data_valid  last
//                       is_empty, is_full, pad to 32
//
// An item is registered in the two-entry command queue before it reaches the sequencer.
// Write, discard and unused kinds are answered from the sequencer's idle state; a read or
// peek of n bytes passes one stored byte per cycle through the ring's read port while the
// result is not stalled. A find makes one compare per cycle on the read port.
// Reset is synchronous and active low and leaves the ring empty; stored bytes are not cleared.
// A stalled result holds the sequencer; the queue keeps accepting until it holds two items.
module byte_ring_fifo_with_search_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // write_byte[7:0], length[14:8], search_byte[22:15]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // data_byte[7:0], count[14:8], found[15], offset[21:16],
                                   // fill_level[28:22], is_empty[29], is_full[30]
    output logic        m_tuser,   // data_valid
    output logic        m_tlast
);

    logic           cmd_valid;
    logic           cmd_pop;
    brfs_pkg::cmd_t cmd;
    brfs_pkg::res_t res;

    brfs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    brfs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (m_tvalid),
        .out_res   (res),
        .out_ready (m_tready)
    );

    // Pack the result item onto the stream.
    assign m_tdata = {1'b0, res.is_full, res.is_empty, res.fill_level, res.offset,
                      res.found, res.count, res.data_byte};
    assign m_tuser = res.data_valid;
    assign m_tlast = res.last;

endmodule

// ===== hw/rtl/brfs_front.sv =====
// Front end: accepts input items, decodes the kind and queues commands.
module brfs_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,
    input  logic [2:0]            s_tuser,
    output logic                  cmd_valid,
    output brfs_pkg::cmd_t        cmd,
    input  logic                  cmd_pop
);

    brfs_pkg::cmd_t q_reg [2];
    logic           wr_sel_reg, wr_sel_next;
    logic           rd_sel_reg, rd_sel_next;
    logic [1:0]     used_reg,   used_next;
    brfs_pkg::cmd_t dec;
    logic           push;

    // Decode the kind and keep only the byte that the operation needs.
    always_comb begin
        dec.length = s_tdata[14:8];
        dec.data   = s_tdata[7:0];
        unique case (s_tuser)
            brfs_pkg::KIND_WRITE:   dec.op = brfs_pkg::OP_WRITE;
            brfs_pkg::KIND_READ:    dec.op = brfs_pkg::OP_READ;
            brfs_pkg::KIND_PEEK:    dec.op = brfs_pkg::OP_PEEK;
            brfs_pkg::KIND_DISCARD: dec.op = brfs_pkg::OP_DISCARD;
            brfs_pkg::KIND_FIND: begin
                dec.op   = brfs_pkg::OP_FIND;
                dec.data = s_tdata[22:15];
            end
            default:                dec.op = brfs_pkg::OP_NONE;
        endcase
    end

    assign s_tready  = (used_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (used_reg != 2'd0);
    assign cmd       = q_reg[rd_sel_reg];

    // Two-entry command queue bookkeeping.
    always_comb begin
        wr_sel_next = wr_sel_reg ^ push;
        rd_sel_next = rd_sel_reg ^ cmd_pop;
        used_next   = used_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_sel_reg <= 1'b0;
            rd_sel_reg <= 1'b0;
            used_reg   <= 2'd0;
        end else begin
            wr_sel_reg <= wr_sel_next;
            rd_sel_reg <= rd_sel_next;
            used_reg   <= used_next;
        end
    end

    // Queue payload needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_sel_reg] <= dec;
        end
    end

endmodule

// ===== hw/rtl/brfs_back.sv =====
// Back end: byte ring storage, pointers, command sequencer and result register.
module brfs_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cmd_valid,
    input  brfs_pkg::cmd_t        cmd,
    output logic                  cmd_pop,
    output logic                  out_valid,
    output brfs_pkg::res_t        out_res,
    input  logic                  out_ready
);

    localparam int PW = brfs_pkg::PTR_W;
    localparam int SW = brfs_pkg::SLOT_W;
    localparam int LW = brfs_pkg::LEN_W;
    localparam logic [PW-1:0] DEPTH_P = PW'(brfs_pkg::DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_FIND = 4'b0100,
        ST_FOUT = 4'b1000
    } state_t;

    state_t         state_reg, state_next;
    logic [PW-1:0]  wp_reg, wp_next;
    logic [PW-1:0]  rp_reg, rp_next;
    logic [PW-1:0]  base_reg, base_next;
    logic [LW-1:0]  n_reg, n_next;
    logic [LW-1:0]  idx_reg, idx_next;
    logic [PW-1:0]  fill_after_reg, fill_after_next;
    logic [7:0]     sbyte_reg, sbyte_next;
    logic           found_reg, found_next;
    logic [brfs_pkg::OFS_W-1:0] pos_reg, pos_next;
    logic           out_valid_reg, out_valid_next;
    brfs_pkg::res_t out_reg, out_next;

    logic [7:0]     mem [brfs_pkg::DEPTH];
    logic [7:0]     rdata_reg;
    logic           mem_we, rd_en;
    logic [SW-1:0]  rd_addr;

    logic [PW-1:0]  fill, clamp, wfill;
    logic           full, out_free, last_byte;
    logic [LW-1:0]  idx_inc;
    logic [PW-1:0]  next_addr;

    // Build a result item; the flags follow from the fill level.
    function automatic brfs_pkg::res_t mk_res(
        input logic [7:0]    data_byte,
        input logic          data_valid,
        input logic          last,
        input logic [LW-1:0] count,
        input logic          found,
        input logic [brfs_pkg::OFS_W-1:0] offset,
        input logic [PW-1:0] fill_level
    );
        brfs_pkg::res_t r;
        r.data_byte  = data_byte;
        r.data_valid = data_valid;
        r.last       = last;
        r.count      = count;
        r.found      = found;
        r.offset     = offset;
        r.fill_level = fill_level;
        r.is_empty   = (fill_level == '0);
        r.is_full    = (fill_level == DEPTH_P);
        return r;
    endfunction

    // Ring status and helpers.
    assign fill      = wp_reg - rp_reg;
    assign full      = (fill == DEPTH_P);
    assign clamp     = (cmd.length > fill) ? fill : cmd.length;
    assign wfill     = fill + {{(PW-1){1'b0}}, !full};
    assign out_free  = !out_valid_reg || out_ready;
    assign idx_inc   = idx_reg + 1'b1;
    assign last_byte = (idx_inc == n_reg);
    assign next_addr = base_reg + idx_inc;

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    // Command sequencer.
    always_comb begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        base_next       = base_reg;
        n_next          = n_reg;
        idx_next        = idx_reg;
        fill_after_next = fill_after_reg;
        sbyte_next      = sbyte_reg;
        found_next      = found_reg;
        pos_next        = pos_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        cmd_pop         = 1'b0;
        mem_we          = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = rp_reg[SW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op) inside
                        brfs_pkg::OP_WRITE: begin
                            mem_we         = !full;
                            wp_next        = wp_reg + {{(PW-1){1'b0}}, !full};
                            out_valid_next = 1'b1;
                            out_next       = mk_res('0, 1'b0, 1'b1,
                                                    {{(LW-1){1'b0}}, !full},
                                                    1'b0, '0, wfill);
                        end
                        brfs_pkg::OP_READ, brfs_pkg::OP_PEEK: begin
                            if (clamp == '0) begin
                                out_valid_next = 1'b1;
                                out_next = mk_res('0, 1'b0, 1'b1, '0, 1'b0, '0, fill);
                            end else begin
                                base_next = rp_reg;
                                n_next    = clamp;
                                idx_next  = '0;
                                rd_en     = 1'b1;
                                if (cmd.op == brfs_pkg::OP_READ) begin
                                    rp_next         = rp_reg + clamp;
                                    fill_after_next = fill - clamp;
                                end else begin
                                    fill_after_next = fill;
                                end
                                state_next = ST_READ;
                            end
                        end
                        brfs_pkg::OP_DISCARD: begin
                            rp_next        = rp_reg + clamp;
                            out_valid_next = 1'b1;
                            out_next = mk_res('0, 1'b0, 1'b1, clamp, 1'b0, '0, fill - clamp);
                        end
                        brfs_pkg::OP_FIND: begin
                            if (fill == '0) begin
                                out_valid_next = 1'b1;
                                out_next = mk_res('0, 1'b0, 1'b1, '0, 1'b0, '0, fill);
                            end else begin
                                base_next       = rp_reg;
                                n_next          = fill;
                                idx_next        = '0;
                                sbyte_next      = cmd.data;
                                fill_after_next = fill;
                                rd_en           = 1'b1;
                                state_next      = ST_FIND;
                            end
                        end
                        default: begin
                            out_valid_next = 1'b1;
                            out_next = mk_res('0, 1'b0, 1'b1, '0, 1'b0, '0, fill);
                        end
                    endcase
                end
            end
            // One stored byte per cycle into the result register while the result is not stalled.
            ST_READ: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next = mk_res(rdata_reg, 1'b1, last_byte, n_reg, 1'b0, '0,
                                      fill_after_reg);
                    if (last_byte) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_inc;
                        rd_en    = 1'b1;
                        rd_addr  = next_addr[SW-1:0];
                    end
                end
            end
            // Compare one stored byte per cycle, oldest first.
            ST_FIND: begin
                if (rdata_reg == sbyte_reg) begin
                    found_next = 1'b1;
                    pos_next   = idx_reg[brfs_pkg::OFS_W-1:0];
                    state_next = ST_FOUT;
                end else if (last_byte) begin
                    found_next = 1'b0;
                    pos_next   = '0;
                    state_next = ST_FOUT;
                end else begin
                    idx_next = idx_inc;
                    rd_en    = 1'b1;
                    rd_addr  = next_addr[SW-1:0];
                end
            end
            ST_FOUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next = mk_res('0, 1'b0, 1'b1, '0, found_reg, pos_reg,
                                      fill_after_reg);
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers and the result payload.
    always_ff @(posedge aclk) begin
        base_reg       <= base_next;
        n_reg          <= n_next;
        idx_reg        <= idx_next;
        fill_after_reg <= fill_after_next;
        sbyte_reg      <= sbyte_next;
        found_reg      <= found_next;
        pos_reg        <= pos_next;
        out_reg        <= out_next;
    end

    // Ring storage: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wp_reg[SW-1:0]] <= cmd.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

endmodule
